// File: src/swcd_pkg.sv
// shared types, constants and crc helper for the sensor word crc deframer
// no dependencies; every other file of the block uses it by scoped names
`default_nettype none

package swcd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [1:0] WORDS_RESET = 2'd2;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       response_start;
	} in_item_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic        crc_good;
		logic [1:0]  word_index;
		logic        last_word;
	} out_item_t;

	// eight msb-first shift steps of the crc register after the byte is xored in
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in);
		logic [7:0] c;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/swcd_in_stage.sv
// input register stage: holds one accepted request until the core takes it
// depends on swcd_pkg for the input item type
`default_nettype none

module swcd_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire swcd_pkg::in_item_t in_data,
	input  wire logic             advance,
	output logic                  valid_s1,
	output swcd_pkg::in_item_t    data_s1
);

	logic load;

	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// File: src/swcd_core.sv
// framing state, crc and word count register; builds one result per crc byte of a framed response
// depends on swcd_pkg for types, phase codes and the crc helper
`default_nettype none

module swcd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_wdata,
	input  wire logic               advance,
	input  wire logic               valid_s1,
	input  wire swcd_pkg::in_item_t data_s1,
	output logic                    res_valid,
	output swcd_pkg::out_item_t     res_item
);

	logic [1:0]       words_q;
	swcd_pkg::phase_t phase_q, phase_d;
	logic [7:0]       high_q, high_d;
	logic [7:0]       low_q, low_d;
	logic [7:0]       crc_q, crc_d;
	logic [1:0]       done_q, done_d;
	logic             discard_q, discard_d;
	logic [1:0]       count_eff;
	logic             good;
	logic             last;

	// a count of zero behaves as one
	assign count_eff = (words_q == 2'd0) ? 2'd1 : words_q;
	assign good      = (crc_q == data_s1.rx_byte);
	assign last      = !good || ({1'b0, done_q} + 3'd1 >= {1'b0, count_eff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= swcd_pkg::WORDS_RESET;
		end else if (cfg_we) begin
			words_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		high_d    = high_q;
		low_d     = low_q;
		crc_d     = crc_q;
		done_d    = done_q;
		discard_d = discard_q;
		if (data_s1.response_start) begin
			discard_d = 1'b0;
			done_d    = 2'd0;
			high_d    = data_s1.rx_byte;
			crc_d     = swcd_pkg::crc8_byte(swcd_pkg::CRC_INIT ^ data_s1.rx_byte);
			phase_d   = swcd_pkg::PH_LOW;
		end else if (!discard_q) begin
			case (phase_q)
				swcd_pkg::PH_HIGH: begin
					high_d  = data_s1.rx_byte;
					crc_d   = swcd_pkg::crc8_byte(swcd_pkg::CRC_INIT ^ data_s1.rx_byte);
					phase_d = swcd_pkg::PH_LOW;
				end
				swcd_pkg::PH_LOW: begin
					// crc_q holds the crc of the high byte; crc_d adds the low byte
					low_d   = data_s1.rx_byte;
					crc_d   = swcd_pkg::crc8_byte(crc_q ^ data_s1.rx_byte);
					phase_d = swcd_pkg::PH_CRC;
				end
				swcd_pkg::PH_CRC: begin
					phase_d = swcd_pkg::PH_HIGH;
					if (last) begin
						discard_d = 1'b1;
					end else begin
						done_d = done_q + 2'd1;
					end
				end
				default: begin
					phase_d = swcd_pkg::PH_HIGH;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res_valid = valid_s1 && !data_s1.response_start && !discard_q &&
			(phase_q == swcd_pkg::PH_CRC);
		res_item.data_word  = {high_q, low_q};
		res_item.crc_good   = good;
		res_item.word_index = done_q;
		res_item.last_word  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= swcd_pkg::PH_HIGH;
			done_q    <= 2'd0;
			discard_q <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_d;
			done_q    <= done_d;
			discard_q <= discard_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			high_q <= high_d;
			low_q  <= low_d;
			crc_q  <= crc_d;
		end
	end

`ifndef ASSERT_OFF
	a_res_only_framed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (phase_q == swcd_pkg::PH_CRC) && !discard_q)
		else $error("result outside crc phase");

	a_last_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res_item.last_word) |=> discard_q)
		else $error("no discard after last word");

	a_start_resyncs: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && data_s1.response_start) |=>
			(phase_q == swcd_pkg::PH_LOW) && !discard_q && (done_q == 2'd0))
		else $error("start mark did not resync framing");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && !res_item.last_word) |->
			({1'b0, res_item.word_index} + 3'd1 < {1'b0, count_eff}))
		else $error("non-last word at or past count");
`endif

endmodule

`default_nettype wire

// File: src/swcd_out_stage.sv
// result register: holds one result until the consumer takes it
// depends on swcd_pkg for the result item type
`default_nettype none

module swcd_out_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire swcd_pkg::out_item_t load_item,
	output logic                     space,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output swcd_pkg::out_item_t      out_data
);

	// the slot frees in the same cycle the consumer takes it
	assign space = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= load_item;
		end
	end

endmodule

`default_nettype wire

// File: src/sensor_word_crc_deframer.sv
// a crc byte is held in the input register, checked by the core logic and its result loaded into the result register
// throughput: one byte per cycle while the core advances; input register, core logic, result register
// the core advances whenever the input register holds a byte and the result register is empty or being taken
// reset: clears framing to discard mode until the first start mark, word count 2
// top level; depends on swcd_pkg, swcd_in_stage, swcd_core and swcd_out_stage
`default_nettype none

module sensor_word_crc_deframer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire swcd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output swcd_pkg::out_item_t      out_data
);

	logic                valid_s1;
	swcd_pkg::in_item_t  data_s1;
	logic                advance;
	logic                space;
	logic                res_valid;
	swcd_pkg::out_item_t res_item;

	assign advance = valid_s1 && space;

	swcd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	swcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	swcd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_item (res_item),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: tb/sv/swcd_tb_pkg.sv
`timescale 1ns / 1ps
// word-level prediction and result checking for the crc word deframer bench
// depends on swcd_pkg for the request/result structs, phase codes and reset count
package swcd_tb_pkg;

	import swcd_pkg::*;

	// bit-serial crc-8, poly 0x31, init 0xff, over a 16-bit word msb first
	function automatic logic [7:0] crc8_word(input logic [15:0] word);
		logic [7:0] crc;
		logic       fb;
		crc = CRC_INIT;
		for (int i = 15; i >= 0; i--) begin
			fb = crc[7] ^ word[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	class deframe_model;
		logic [1:0] word_count;
		phase_t     frame_phase;
		logic [7:0] hi_byte;
		logic [7:0] lo_byte;
		logic [1:0] words_seen;
		bit         dropping;
		out_item_t  expected_words[$];
		int unsigned mismatches;

		function new();
			word_count = WORDS_RESET;
			frame_phase = PH_HIGH;
			hi_byte = 8'h00;
			lo_byte = 8'h00;
			words_seen = 2'd0;
			dropping = 1'b1;
			mismatches = 0;
		endfunction

		function void set_count(input logic [1:0] value);
			word_count = value;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void flag(input string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// accepted request: advance framing, queue a word on every crc byte of a framed response
		function void note_byte(input in_item_t req);
			out_item_t  w;
			logic [2:0] limit;
			bit         good;
			limit = (word_count == 2'd0) ? 3'd1 : {1'b0, word_count};
			if (req.response_start) begin
				dropping = 1'b0;
				words_seen = 2'd0;
				hi_byte = req.rx_byte;
				frame_phase = PH_LOW;
				return;
			end
			if (dropping)
				return;
			case (frame_phase)
				PH_HIGH: begin
					hi_byte = req.rx_byte;
					frame_phase = PH_LOW;
				end
				PH_LOW: begin
					lo_byte = req.rx_byte;
					frame_phase = PH_CRC;
				end
				default: begin
					good = (crc8_word({hi_byte, lo_byte}) == req.rx_byte);
					w.data_word = {hi_byte, lo_byte};
					w.crc_good = good;
					w.word_index = words_seen;
					w.last_word = !good || ({1'b0, words_seen} + 3'd1 >= limit);
					expected_words.push_back(w);
					frame_phase = PH_HIGH;
					if (w.last_word)
						dropping = 1'b1;
					else
						words_seen = words_seen + 2'd1;
				end
			endcase
		endfunction

		function void check_word(input out_item_t got);
			out_item_t want;
			if (expected_words.size() == 0) begin
				flag($sformatf("unexpected word: data %h good %b idx %0d last %b",
					got.data_word, got.crc_good, got.word_index, got.last_word));
				return;
			end
			want = expected_words.pop_front();
			if (got.data_word !== want.data_word || got.crc_good !== want.crc_good ||
				got.word_index !== want.word_index || got.last_word !== want.last_word) begin
				flag($sformatf("word mismatch: exp data %h good %b idx %0d last %b, got data %h good %b idx %0d last %b",
					want.data_word, want.crc_good, want.word_index, want.last_word,
					got.data_word, got.crc_good, got.word_index, got.last_word));
			end
		endfunction

		function void finish_check();
			if (expected_words.size() != 0)
				flag($sformatf("%0d expected words never arrived", expected_words.size()));
		endfunction
	endclass

endpackage

// File: tb/sv/tb_sensor_word_crc_deframer.sv
`timescale 1ns / 1ps
// top of the crc word deframer bench: clock, reset, request driver and result sink
// depends on swcd_pkg, swcd_tb_pkg and the sensor_word_crc_deframer rtl
module tb_sensor_word_crc_deframer;

	import swcd_pkg::*;
	import swcd_tb_pkg::*;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;

	deframe_model sb;
	int          burst_left = 0;
	int unsigned bytes_sent = 0;
	logic [15:0] rx_tick = 16'd0;
	rx_mode_t    rx_mode = RX_OPEN;

	sensor_word_crc_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// receiver: switches between open, coin-flip, sparse and periodic stalls
	always @(negedge clk) begin
		rx_tick <= rx_tick + 16'd1;
		if (rx_tick[6:0] == 7'd0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: out_ready <= ((rx_tick % 5) != 0);
			default:     out_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_word(out_data);
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 15))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one request; sender runs in bursts with random gaps in between
	task automatic send_byte(input logic [7:0] b, input logic s);
		in_item_t req;
		int       gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
		end
		burst_left--;
		req.rx_byte = b;
		req.response_start = s;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(req);
		bytes_sent++;
	endtask

	// one word as a triple; crc_flip = 0 sends the correct crc
	task automatic send_word(input logic [15:0] w, input logic first, input logic [7:0] crc_flip);
		send_byte(w[15:8], first);
		send_byte(w[7:0], 1'b0);
		send_byte(crc8_word(w) ^ crc_flip, 1'b0);
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		// a crc byte passes the input and result registers, framing bytes yield nothing
		repeat (6) @(negedge clk);
	endtask

	task automatic write_count(input logic [1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.set_count(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly full responses; some cut short, some longer or shorter than the count
	task automatic send_response(input bit broken);
		int          limit;
		int          nw;
		int          cut;
		int          idx;
		logic [7:0]  trip[3];
		logic [15:0] w;
		limit = (sb.word_count == 2'd0) ? 1 : int'(sb.word_count);
		nw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : limit;
		cut = broken ? $urandom_range(1, nw * 3 - 1) : nw * 3;
		idx = 0;
		for (int k = 0; k < nw; k++) begin
			w = {rand_byte(), rand_byte()};
			trip[0] = w[15:8];
			trip[1] = w[7:0];
			trip[2] = crc8_word(w);
			if ($urandom_range(0, 9) == 0)
				trip[2] = trip[2] ^ 8'($urandom_range(1, 255));
			for (int j = 0; j < 3; j++) begin
				if (idx < cut)
					send_byte(trip[j], (k == 0 && j == 0));
				idx++;
			end
		end
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned stop_at;
		int          r;
		stop_at = bytes_sent + quota;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_response(1'b0);
			end else if (r < 88) begin
				send_response(1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					send_byte(rand_byte(), ($urandom_range(0, 5) == 0));
			end
		end
	endtask

	initial begin
		logic [1:0] counts[6];
		counts = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset count of two words
		send_byte(8'hFF, 1'b0);                 // dropped before any start mark
		send_word(16'h0000, 1'b1, 8'h00);
		send_word(16'hFFFF, 1'b0, 8'h00);       // last by count
		send_byte(8'h12, 1'b0);                 // dropped after last
		send_word(16'hBEEF, 1'b1, 8'h01);       // bad crc ends response early
		send_byte(8'hA5, 1'b0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h22, 1'b0);
		send_word(16'h3344, 1'b1, 8'h00);       // start mark restarts mid word
		send_byte(8'h55, 1'b0);
		send_byte(8'h66, 1'b1);                 // start mark on what would be a low byte
		send_byte(8'h77, 1'b0);
		send_byte(crc8_word(16'h6677), 1'b0);
		send_word(16'h8001, 1'b0, 8'h80);       // bad crc on word one
		random_phase(200);
		settle();

		foreach (counts[p]) begin
			write_count(counts[p]);
			if (p == 2)
				send_word(16'h7FFE, 1'b1, 8'h00);  // count zero acts as one
			random_phase(230);
			settle();
		end

		repeat (10) @(posedge clk);
		sb.finish_check();
		if (sb.mismatches == 0) begin
			$display("[sensor_word_crc_deframer] OK");
		end else begin
			$display("[sensor_word_crc_deframer] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[sensor_word_crc_deframer] ERROR");
		$finish;
	end

endmodule
